FILE: rtl/led_blink_controller_assert.svh
// Assertion macros shared by the LED blink controller RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef LED_BLINK_CONTROLLER_ASSERT_SVH
`define LED_BLINK_CONTROLLER_ASSERT_SVH

// Checked only outside reset.
`define LBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked in every cycle, reset included.
`define LBC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/lbc_pkg.sv
// Package for the LED blink controller: sizes, operation, status and mode codes,
// the per-channel command struct and the time saturation helper. No dependencies.
package lbc_pkg;

  localparam int NUM_LEDS   = 8;
  localparam int TIME_WIDTH = 16;
  localparam int ID_W       = 3;
  localparam int LED_SLOTS  = 1 << ID_W;
  localparam int IN_TIME_W  = 16;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [ID_W-1:0]       led_id_t;
  typedef logic [LED_SLOTS-1:0]  led_vec_t;

  localparam time_t    TIME_MAX = '1;
  localparam led_vec_t LED_MASK = LED_SLOTS'((16'd1 << NUM_LEDS) - 16'd1);

  // Configuration register indexes
  localparam logic REG_ACTIVE_HIGH = 1'b0;
  localparam logic REG_PRESENT     = 1'b1;

  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_ON    = 2'd1,
    FN_OFF   = 2'd2,
    FN_CHECK = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_NOCFG   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_PULSE_WAIT = 3'd1,
    MODE_PULSE_LIT  = 3'd2,
    MODE_BLINK_WAIT = 3'd3,
    MODE_BLINK_LIT  = 3'd4,
    MODE_BLINK_DARK = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    CH_NONE = 2'd0,
    CH_TICK = 2'd1,
    CH_ON   = 2'd2,
    CH_OFF  = 2'd3
  } chan_op_t;

  typedef struct packed {
    chan_op_t op;
    time_t    dly;
    time_t    onm;
    time_t    per;
  } chan_cmd_t;

  // Clamp an incoming time field to the internal time width
  function automatic time_t sat_time(input logic [IN_TIME_W-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 > 32'(TIME_MAX)) begin
      return TIME_MAX;
    end
    return TIME_WIDTH'(v32);
  endfunction

endpackage

FILE: rtl/lbc_chan.sv
// One LED channel of the blink controller: mode, phase counter, stored timing, lit bit.
// Depends on lbc_pkg and led_blink_controller_assert.svh.
`include "led_blink_controller_assert.svh"

module lbc_chan (
  input  logic               clk,
  input  logic               rst,
  input  lbc_pkg::chan_cmd_t cmd,
  output lbc_pkg::mode_t     mode,
  output logic               lit,
  output logic               lit_next
);

  lbc_pkg::mode_t mode_next;
  lbc_pkg::time_t count, count_next;
  lbc_pkg::time_t on_time, on_time_next;
  lbc_pkg::time_t period, period_next;

  always_comb begin
    mode_next    = mode;
    count_next   = count;
    on_time_next = on_time;
    period_next  = period;
    lit_next     = lit;
    case (cmd.op)
      lbc_pkg::CH_TICK: begin
        if (mode != lbc_pkg::MODE_IDLE) begin
          if (count > lbc_pkg::time_t'(1)) begin
            count_next = count - lbc_pkg::time_t'(1);
          end else begin
            case (mode)
              lbc_pkg::MODE_PULSE_WAIT: begin
                mode_next  = lbc_pkg::MODE_PULSE_LIT;
                count_next = on_time;
                lit_next   = 1'b1;
              end
              lbc_pkg::MODE_PULSE_LIT: begin
                mode_next  = lbc_pkg::MODE_IDLE;
                count_next = '0;
                lit_next   = 1'b0;
              end
              lbc_pkg::MODE_BLINK_WAIT, lbc_pkg::MODE_BLINK_DARK: begin
                mode_next  = lbc_pkg::MODE_BLINK_LIT;
                count_next = on_time;
                lit_next   = 1'b1;
              end
              lbc_pkg::MODE_BLINK_LIT: begin
                mode_next  = lbc_pkg::MODE_BLINK_DARK;
                count_next = period - on_time;
                lit_next   = 1'b0;
              end
              default: begin
                mode_next = mode;
              end
            endcase
          end
        end
      end
      lbc_pkg::CH_ON: begin
        // Checks already passed upstream; pick blink, pulse or steady
        if (cmd.per != '0) begin
          on_time_next = cmd.onm;
          period_next  = cmd.per;
          if (cmd.dly != '0) begin
            mode_next  = lbc_pkg::MODE_BLINK_WAIT;
            count_next = cmd.dly;
          end else begin
            mode_next  = lbc_pkg::MODE_BLINK_LIT;
            count_next = cmd.onm;
            lit_next   = 1'b1;
          end
        end else if (cmd.onm != '0) begin
          on_time_next = cmd.onm;
          period_next  = '0;
          if (cmd.dly != '0) begin
            mode_next  = lbc_pkg::MODE_PULSE_WAIT;
            count_next = cmd.dly;
          end else begin
            mode_next  = lbc_pkg::MODE_PULSE_LIT;
            count_next = cmd.onm;
            lit_next   = 1'b1;
          end
        end else if (cmd.dly == '0) begin
          mode_next  = lbc_pkg::MODE_IDLE;
          count_next = '0;
          lit_next   = 1'b1;
        end
      end
      lbc_pkg::CH_OFF: begin
        mode_next  = lbc_pkg::MODE_IDLE;
        count_next = '0;
        lit_next   = 1'b0;
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= lbc_pkg::MODE_IDLE;
      count   <= '0;
      on_time <= '0;
      period  <= '0;
      lit     <= 1'b0;
    end else begin
      mode    <= mode_next;
      count   <= count_next;
      on_time <= on_time_next;
      period  <= period_next;
      lit     <= lit_next;
    end
  end

  `LBC_ASSERT(a_idle_count_zero, (mode == lbc_pkg::MODE_IDLE) |-> (count == '0), "idle channel with a running count")
  `LBC_ASSERT(a_blink_timing, ((mode == lbc_pkg::MODE_BLINK_WAIT) || (mode == lbc_pkg::MODE_BLINK_LIT) || (mode == lbc_pkg::MODE_BLINK_DARK)) |-> (on_time < period), "blink with on-time not below period")
  `LBC_ASSERT(a_lit_phase, ((mode == lbc_pkg::MODE_PULSE_LIT) || (mode == lbc_pkg::MODE_BLINK_LIT)) |-> lit, "lit phase with LED dark")
  `LBC_ASSERT(a_dark_phase, (mode == lbc_pkg::MODE_BLINK_DARK) |-> !lit, "dark phase with LED lit")

endmodule

FILE: rtl/led_blink_controller.sv
// LED blink controller top: input stage, command decode, eight channels, result register.
// The input stage registers each item; the result register loads when the staged item advances,
// and the result can then transfer. Throughput: one item per cycle while the output is not
// stalled. The input stage and the result register each hold one item; ready drops only when
// both are full and the output is stalled. Synchronous active-high reset idles all channels,
// darkens all LEDs, sets the polarity mask to all active-high and the present mask to zero.
`include "led_blink_controller_assert.svh"

module led_blink_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // led_id[2:0], delay_ms[18:3], on_ms[34:19], period_ms[50:35]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[1:0], lit[2], pin_levels[10:3]
);

  logic [7:0] active_high_mask;
  logic [7:0] present_mask;

  // Input stage
  logic                stg_valid;
  lbc_pkg::func_t      stg_func;
  lbc_pkg::led_id_t    stg_id;
  lbc_pkg::time_t      stg_dly, stg_onm, stg_per;
  logic                advance, in_xfer;

  // Result register
  lbc_pkg::status_t    res_status;
  logic                res_lit;
  logic [7:0]          res_pins;

  lbc_pkg::status_t    status;
  logic                lit_sel;
  lbc_pkg::chan_op_t   base_op;
  logic                id_ok, present_sel;
  lbc_pkg::mode_t      mode_sel;

  lbc_pkg::chan_cmd_t  cmds [lbc_pkg::LED_SLOTS];
  lbc_pkg::mode_t      modes [lbc_pkg::LED_SLOTS];
  lbc_pkg::led_vec_t   lit_now, lit_nxt;

  assign advance  = stg_valid && (!m_tvalid || m_tready);
  assign s_tready = !stg_valid || advance;
  assign in_xfer  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_high_mask <= 8'hFF;
      present_mask     <= 8'h00;
    end else if (cfg_we) begin
      case (cfg_index)
        lbc_pkg::REG_ACTIVE_HIGH: active_high_mask <= cfg_wdata;
        lbc_pkg::REG_PRESENT:     present_mask     <= cfg_wdata;
        default:                  present_mask     <= present_mask;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_xfer) begin
      stg_valid <= 1'b1;
    end else if (advance) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_func <= lbc_pkg::func_t'(s_tuser);
      stg_id   <= s_tdata[2:0];
      stg_dly  <= lbc_pkg::sat_time(s_tdata[18:3]);
      stg_onm  <= lbc_pkg::sat_time(s_tdata[34:19]);
      stg_per  <= lbc_pkg::sat_time(s_tdata[50:35]);
    end
  end

  // Decode the staged item against current channel state
  always_comb begin
    id_ok       = 32'(stg_id) < lbc_pkg::NUM_LEDS;
    present_sel = id_ok && present_mask[stg_id];
    mode_sel    = modes[stg_id];
    status      = lbc_pkg::ST_OK;
    lit_sel     = 1'b0;
    base_op     = lbc_pkg::CH_NONE;
    case (stg_func)
      lbc_pkg::FN_TICK: begin
        base_op = lbc_pkg::CH_TICK;
      end
      lbc_pkg::FN_ON: begin
        if (mode_sel inside {lbc_pkg::MODE_BLINK_WAIT, lbc_pkg::MODE_BLINK_LIT,
                             lbc_pkg::MODE_BLINK_DARK}) begin
          status = lbc_pkg::ST_BUSY;
        end else if (!present_sel) begin
          status = lbc_pkg::ST_NOCFG;
        end else if ((stg_per != '0) && ((stg_onm == '0) || (stg_per <= stg_onm))) begin
          status = lbc_pkg::ST_INVALID;
        end else begin
          base_op = lbc_pkg::CH_ON;
        end
      end
      lbc_pkg::FN_OFF: begin
        if (!present_sel) begin
          status = lbc_pkg::ST_NOCFG;
        end else begin
          base_op = lbc_pkg::CH_OFF;
        end
      end
      lbc_pkg::FN_CHECK: begin
        if (!present_sel) begin
          status = lbc_pkg::ST_NOCFG;
        end else begin
          lit_sel = lit_now[stg_id];
        end
      end
      default: begin
        base_op = lbc_pkg::CH_NONE;
      end
    endcase
    if (!advance) begin
      base_op = lbc_pkg::CH_NONE;
    end
  end

  // Broadcast ticks; steer on and off to the addressed channel only
  always_comb begin
    for (int i = 0; i < lbc_pkg::LED_SLOTS; i++) begin
      cmds[i].op  = ((base_op == lbc_pkg::CH_TICK) ||
                     (stg_id == lbc_pkg::ID_W'(i))) ? base_op : lbc_pkg::CH_NONE;
      cmds[i].dly = stg_dly;
      cmds[i].onm = stg_onm;
      cmds[i].per = stg_per;
    end
  end

  for (genvar g = 0; g < lbc_pkg::LED_SLOTS; g++) begin : g_chan
    if (g < lbc_pkg::NUM_LEDS) begin : g_real
      lbc_chan u_chan (
        .clk      (clk),
        .rst      (rst),
        .cmd      (cmds[g]),
        .mode     (modes[g]),
        .lit      (lit_now[g]),
        .lit_next (lit_nxt[g])
      );
    end else begin : g_absent
      assign modes[g]   = lbc_pkg::MODE_IDLE;
      assign lit_now[g] = 1'b0;
      assign lit_nxt[g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_status <= status;
      res_lit    <= lit_sel;
      res_pins   <= ~(lit_nxt ^ active_high_mask) & present_mask & lbc_pkg::LED_MASK;
    end
  end

  assign m_tdata = {5'b0, res_pins, res_lit, res_status};

  `LBC_ASSERT_ALWAYS(a_reset_empty,
    rst |=> (!m_tvalid && !stg_valid),
    "pipeline not empty after reset")
  `LBC_ASSERT(a_stall_hold,
    (stg_valid && !advance) |=> (stg_valid && $stable(stg_func) && $stable(stg_id)),
    "staged item lost while stalled")
  `LBC_ASSERT(a_ready_full,
    !s_tready |-> (stg_valid && m_tvalid && !m_tready),
    "ready low without a full stalled pipeline")
  `LBC_ASSERT(a_lit_ok,
    (m_tvalid && res_lit) |-> (res_status == lbc_pkg::ST_OK),
    "lit reported with an error status")

endmodule
